FILE: hw/rtl/dip_pkg.sv
// ----------------------------------------------------------------------------
// dip_pkg: shared types and constants of the dictionary index 7-bit packer
// Holds the channel payload structs, the function codes and the command and
// status groups that join the controller and the datapath.
// ----------------------------------------------------------------------------
package dip_pkg;

	// Default dictionary depth (entries)
	localparam int DICT_DEPTH_DEF = 127;

	// Width of one packed code and the end-of-stream terminator code
	localparam int       CODE_W    = 7;
	localparam logic [6:0] TERM_CODE = 7'h7F;

	// Function codes of an input transaction
	localparam logic [1:0] FUNC_LOAD = 2'd0;
	localparam logic [1:0] FUNC_DATA = 2'd1;
	localparam logic [1:0] FUNC_EOS  = 2'd2;

	// Input transaction payload
	typedef struct packed {
		logic [1:0] func;
		logic [6:0] entry_index;
		logic [7:0] entry_char;
		logic [7:0] data_byte;
	} dip_in_t;

	// Output transaction payload
	typedef struct packed {
		logic [7:0] packed_byte;
		logic       last_of_stream;
		logic       not_in_table;
	} dip_out_t;

	// Source of an output byte
	typedef enum logic [1:0] {
		OSEL_BYTE = 2'd0,
		OSEL_TAIL = 2'd1,
		OSEL_MISS = 2'd2
	} dip_osel_t;

	// Controller to datapath commands
	typedef struct packed {
		logic      mem_we;
		logic      scan_start;
		logic      scan_run;
		logic      pack_data;
		logic      pack_term;
		logic      pack_clear;
		logic      out_load;
		dip_osel_t out_sel;
		logic      out_last;
	} dip_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic hit;
		logic miss;
		logic phase_nz;
		logic out_free;
	} dip_sts_t;

endpackage

FILE: hw/rtl/dip_ctrl.sv
// ----------------------------------------------------------------------------
// dip_ctrl: sequencing controller of the dictionary index 7-bit packer
// Accepts one transaction at a time, steers the dictionary scan, the code
// packer and the loading of result bytes into the output register.
// ----------------------------------------------------------------------------
module dip_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        in_func,
	output logic              in_stall,
	output dip_pkg::dip_cmd_t cmd,
	input  dip_pkg::dip_sts_t sts
);
	import dip_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE      = 6'b000001,
		ST_SCAN      = 6'b000010,
		ST_PACK_EOS  = 6'b000100,
		ST_EMIT_BYTE = 6'b001000,
		ST_EMIT_TAIL = 6'b010000,
		ST_EMIT_MISS = 6'b100000
	} dip_state_t;

	dip_state_t state_q, state_d;
	logic       eos_q, eos_d;
	logic       accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);

	// Next state and command decode
	always_comb begin
		state_d        = state_q;
		eos_d          = eos_q;
		cmd            = '0;
		cmd.out_sel    = OSEL_BYTE;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					priority case (in_func)
						FUNC_LOAD: begin
							cmd.mem_we = 1'b1;
						end
						FUNC_DATA: begin
							cmd.scan_start = 1'b1;
							eos_d          = 1'b0;
							state_d        = ST_SCAN;
						end
						FUNC_EOS: begin
							eos_d = 1'b1;
							if (sts.phase_nz) begin
								state_d = ST_PACK_EOS;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_SCAN: begin
				cmd.scan_run = 1'b1;
				if (sts.hit) begin
					cmd.pack_data = 1'b1;
					state_d       = sts.phase_nz ? ST_EMIT_BYTE : ST_IDLE;
				end else if (sts.miss) begin
					state_d = ST_EMIT_MISS;
				end
			end
			ST_PACK_EOS: begin
				cmd.pack_term = 1'b1;
				state_d       = ST_EMIT_BYTE;
			end
			ST_EMIT_BYTE: begin
				cmd.out_sel  = OSEL_BYTE;
				cmd.out_last = eos_q && !sts.phase_nz;
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = (eos_q && sts.phase_nz) ? ST_EMIT_TAIL : ST_IDLE;
				end
			end
			ST_EMIT_TAIL: begin
				cmd.out_sel  = OSEL_TAIL;
				cmd.out_last = 1'b1;
				if (sts.out_free) begin
					cmd.out_load   = 1'b1;
					cmd.pack_clear = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			ST_EMIT_MISS: begin
				cmd.out_sel = OSEL_MISS;
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			eos_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			eos_q   <= eos_d;
		end
	end

endmodule

FILE: hw/rtl/dip_dpath.sv
// ----------------------------------------------------------------------------
// dip_dpath: datapath of the dictionary index 7-bit packer
// Dictionary memory with a one-entry-per-cycle scan, the MSB-first code
// packer and the output register that holds one result transaction.
// ----------------------------------------------------------------------------
module dip_dpath #(
	parameter int DICT_DEPTH = dip_pkg::DICT_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dip_pkg::dip_in_t   in_data,
	input  logic [6:0]         dict_size,
	input  dip_pkg::dip_cmd_t  cmd,
	output dip_pkg::dip_sts_t  sts,
	output logic               out_valid,
	input  logic               out_stall,
	output dip_pkg::dip_out_t  out_data
);
	import dip_pkg::*;

	localparam int IDX_W = (DICT_DEPTH > 1) ? $clog2(DICT_DEPTH) : 1;
	localparam int CNT_W = $clog2(DICT_DEPTH + 1);

	logic [7:0]        mem [DICT_DEPTH];
	logic [7:0]        rd_data_q;
	logic [IDX_W-1:0]  rd_idx_q;
	logic              rd_valid_q;
	logic [CNT_W-1:0]  addr_q;
	logic [CNT_W-1:0]  limit_q;
	logic [7:0]        data_q;
	logic [6:0]        lim7;
	logic              load_ok;
	logic              addr_in_range;

	logic [2:0]        phase_q;
	logic [7:0]        partial_q;
	logic [7:0]        byte_q;
	logic [CODE_W-1:0] code;
	logic [15:0]       code_wide;
	logic [7:0]        byte_d;

	logic              out_valid_q;
	dip_out_t          out_q;
	logic              out_free;

	// Search limit and address checks
	assign lim7          = (dict_size > 7'(DICT_DEPTH)) ? 7'(DICT_DEPTH) : dict_size;
	assign load_ok       = (in_data.entry_index < 7'(DICT_DEPTH));
	assign addr_in_range = (addr_q < limit_q);

	// Dictionary memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.mem_we && load_ok) begin
			mem[in_data.entry_index[IDX_W-1:0]] <= in_data.entry_char;
		end
		if (cmd.scan_run && addr_in_range) begin
			rd_data_q <= mem[addr_q[IDX_W-1:0]];
			rd_idx_q  <= addr_q[IDX_W-1:0];
		end
	end

	// Latched byte under search and its limit
	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			data_q  <= in_data.data_byte;
			limit_q <= CNT_W'(lim7);
		end
	end

	// Scan address counter and read-valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q     <= '0;
			rd_valid_q <= 1'b0;
		end else if (cmd.scan_start) begin
			addr_q     <= '0;
			rd_valid_q <= 1'b0;
		end else if (cmd.scan_run) begin
			rd_valid_q <= addr_in_range;
			if (addr_in_range) begin
				addr_q <= addr_q + CNT_W'(1);
			end
		end
	end

	// Code packer: byte completes from pending bits, remainder left-aligned
	assign code      = cmd.pack_term ? TERM_CODE : CODE_W'(rd_idx_q);
	assign byte_d    = partial_q | 8'(code >> (3'd7 - phase_q));
	assign code_wide = {9'b0, code} << ({1'b0, phase_q} + 4'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= '0;
			partial_q <= '0;
		end else if (cmd.pack_clear) begin
			phase_q   <= '0;
			partial_q <= '0;
		end else if (cmd.pack_data || cmd.pack_term) begin
			phase_q   <= phase_q + 3'd1;
			partial_q <= code_wide[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pack_data || cmd.pack_term) begin
			byte_q <= byte_d;
		end
	end

	// Output register
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			unique case (cmd.out_sel)
				OSEL_BYTE: out_q.packed_byte <= byte_q;
				OSEL_TAIL: out_q.packed_byte <= partial_q;
				default:   out_q.packed_byte <= 8'h00;
			endcase
			out_q.last_of_stream <= cmd.out_last;
			out_q.not_in_table   <= (cmd.out_sel == OSEL_MISS);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Status to the controller
	assign sts.hit      = rd_valid_q && (rd_data_q == data_q);
	assign sts.miss     = !rd_valid_q && !addr_in_range;
	assign sts.phase_nz = (phase_q != 3'd0);
	assign sts.out_free = out_free;

endmodule

FILE: hw/rtl/dictionary_index_7bit_packer.sv
// ----------------------------------------------------------------------------
// dictionary_index_7bit_packer: dictionary lookup and 7-bit code packer
// Maps data bytes to their lowest index in the loaded dictionary, packs the
// 7-bit codes MSB-first into bytes; EOS ends pending bits with a terminator.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  channel takes one transaction at a time: dictionary loads, data
//         bytes and end-of-stream marks, selected by the func field.
//   out_* channel gives packed bytes, miss reports and the flushed tail.
//   APB port holds dict_size at address 0 (number of entries searched);
//   write it only while the block is idle.
// Timing:
//   A load does not leave idle. A data byte is scanned from index 0 up to
//   the limit, one entry per cycle, as the dictionary memory has one read
//   port; a hit packs its code and, when pending bits complete a byte, loads
//   that byte into the output register, and a miss loads a miss report. An
//   end of stream gives up to two results.
//   The next transaction is taken once the last result is in the output
//   register, even while the receiver still stalls it.
// Reset:
//   Clears the packer phase, pending bits, dict_size and the output valid;
//   dictionary contents stay undefined until loaded. A stalled result holds.
// ----------------------------------------------------------------------------
module dictionary_index_7bit_packer #(
	parameter int DICT_DEPTH = dip_pkg::DICT_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  dip_pkg::dip_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output dip_pkg::dip_out_t out_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import dip_pkg::*;

	dip_cmd_t   cmd;
	dip_sts_t   sts;
	logic [6:0] dict_size_q;
	logic       reg_sel;

	// Register decode: dict_size is the only register, at word 0
	assign reg_sel = (paddr[2] == 1'b0);
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? {25'b0, dict_size_q} : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dict_size_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			dict_size_q <= pwdata[6:0];
		end
	end

	// Controller
	dip_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_func  (in_data.func),
		.in_stall (in_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	// Datapath
	dip_dpath #(
		.DICT_DEPTH (DICT_DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.dict_size (dict_size_q),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

FILE: hw/rtl/dip_checker.sv
// ----------------------------------------------------------------------------
// dip_checker: port-level checks of the dictionary index 7-bit packer
// Watches the channels of the top level and flags results or handshake
// behaviour that the packer must never show.
// ----------------------------------------------------------------------------
module dip_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input dip_pkg::dip_in_t  in_data,
	input logic              out_valid,
	input logic              out_stall,
	input dip_pkg::dip_out_t out_data
);
	import dip_pkg::*;

	// A stalled result transaction stays offered
	a_out_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result transaction keeps its payload
	a_out_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_data))
		else $error("result payload changed while stalled");

	// A miss report carries a zero byte and never ends a stream
	a_miss_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.not_in_table |->
			out_data.packed_byte == 8'h00 && !out_data.last_of_stream)
		else $error("miss report with byte or last flag");

	// A dictionary load never holds off the next transaction
	a_load_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.func == FUNC_LOAD |=> !in_stall)
		else $error("stall after dictionary load");

endmodule

bind dictionary_index_7bit_packer dip_checker u_dip_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
